// ===== rtl/core/pcl_pkg.sv =====
// Shared types, constants and fixed-point helpers of the PID cost search block.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package pcl_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ACC_W     = 65;
	localparam int DIV_W     = 50;
	localparam int DVS_W     = 19;
	localparam int DIV_ITER  = DIV_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

	localparam logic [63:0] PI_Q32 = 64'd13493037705;
	localparam logic signed [31:0] PI_FIX =
		32'((PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
	localparam logic [DVS_W-1:0] TWO_PI_FIX = DVS_W'(2 * PI_FIX);
	localparam logic signed [ACC_W-1:0] FORCE_MAX = ACC_W'(20 <<< FRAC_BITS);
	localparam logic signed [ACC_W-1:0] HALF_LSB  = ACC_W'(1 <<< (FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] SAT_HI    = ACC_W'(64'sh7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] SAT_LO    = ACC_W'(-64'sh8000_0000);
	localparam logic [47:0] COST_MAX = {48{1'b1}};

	typedef enum logic [2:0] {
		CFG_SETPOINT   = 3'd0,
		CFG_TIME_STEP  = 3'd1,
		CFG_STEPS      = 3'd2,
		CFG_ROLL_START = 3'd3,
		CFG_ROLL_STEP  = 3'd4,
		CFG_ROLL_COUNT = 3'd5,
		CFG_TORQUE     = 3'd6,
		CFG_DAMPING    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [18:0] setpoint;
		logic [16:0] time_step;
		logic [11:0] steps_per_run;
		logic [18:0] roll_start;
		logic [17:0] roll_step;
		logic [6:0]  roll_count;
		logic [30:0] torque_gain;
		logic [30:0] damping_gain;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		setpoint:      19'd0,
		time_step:     17'd6554,
		steps_per_run: 12'd51,
		roll_start:    19'(-51472),
		roll_step:     18'd17157,
		roll_count:    7'd7,
		torque_gain:   31'd1260,
		damping_gain:  31'd840
	};

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_SKIP, OP_RUN_INIT, OP_RUN_END, OP_ERR, OP_EDT,
		OP_INTEG, OP_KP, OP_KI, OP_DER, OP_KD_MUL, OP_KD, OP_U, OP_UT_MUL,
		OP_UT, OP_DR, OP_ACCEL, OP_ADT_MUL, OP_RATE, OP_RDT_MUL, OP_ANGLE,
		OP_WRAP, OP_WRAP_FIX, OP_COST, OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic roll_done;
		logic start_zero;
		logic steps_done;
		logic div_busy;
		logic wrap_need;
		logic out_free;
	} stat_t;

	// Add half an LSB and shift right by FRAC_BITS: round to nearest, ties up.
	function automatic logic signed [ACC_W-1:0] fx_rnd(input logic signed [ACC_W-1:0] v);
		fx_rnd = (v + HALF_LSB) >>> FRAC_BITS;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end
		sat32 = r[31:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pcl_div.sv =====
// Radix-4 restoring divider, two quotient bits per cycle, shared by the datapath.
// Depends on pcl_pkg for its widths.
`default_nettype none

module pcl_div import pcl_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic [DIV_W-1:0]      quotient,
	output logic [DVS_W-1:0]      remainder
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]     rem_q, dvs_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DVS_W:0]       r1, s1, r2, s2;
	logic                 ge1, ge2;

	always_comb begin
		r1  = {rem_q, quo_q[DIV_W-1]};
		ge1 = r1 >= {1'b0, dvs_q};
		s1  = ge1 ? r1 - {1'b0, dvs_q} : r1;
		r2  = {s1[DVS_W-1:0], quo_q[DIV_W-2]};
		ge2 = r2 >= {1'b0, dvs_q};
		s2  = ge2 ? r2 - {1'b0, dvs_q} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_ITER);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			rem_q <= s2[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-3:0], ge1, ge2};
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/pcl_dp.sv =====
// Datapath: plant and PID state, shared multiplier, divider, cost and best tracking.
// Depends on pcl_pkg and pcl_div; driven one operation per cycle by pcl_ctrl unless it stalls.
`default_nettype none

module pcl_dp import pcl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire cmd_t        cmd,
	output stat_t            stat,
	input  wire logic [24:0] in_gain_p,
	input  wire logic [24:0] in_gain_i,
	input  wire logic [24:0] in_gain_d,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [47:0]      out_cost,
	output logic             out_new_best,
	output logic [24:0]      out_best_p,
	output logic [24:0]      out_best_i,
	output logic [24:0]      out_best_d
);

	logic [24:0]        gp_q, gi_q, gd_q;
	logic signed [31:0] integ_q, last_q, err_q, der_q, rate_q, angle_q, accel_q;
	logic signed [21:0] u_q;
	logic signed [63:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [34:0] araw_q;
	logic signed [26:0] start_q;
	logic [6:0]         k_q, runs_q;
	logic [11:0]        step_q;
	logic [47:0]        sum_q, low_cost_q, cost_q;
	logic               sat_q, neg_q, wpos_q, valid_q, flag_q;
	logic [24:0]        best_p_q, best_i_q, best_d_q, bp_q, bi_q, bd_q;

	logic signed [32:0]      ma, mb;
	logic signed [65:0]      mul_full;
	logic                    mul_en;
	logic signed [ACC_W-1:0] sp, e_wide, diff, mag, rnd_prod, rnd_acc, qs, qv;
	logic signed [ACC_W-1:0] awrap, remw, fixv, araw_w;
	logic signed [31:0]      e_next;
	logic signed [21:0]      u_next;
	logic [48:0]             sum_next;
	logic                    div_start, div_busy, wrap_need, trivial, better;
	logic [DIV_W-1:0]        div_dividend, div_quo;
	logic [DVS_W-1:0]        div_divisor, div_rem;
	logic [47:0]             cost_v;

	pcl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Shared multiplier operand selection.
	always_comb begin
		ma     = '0;
		mb     = '0;
		mul_en = 1'b1;
		unique case (cmd.op)
			OP_EDT: begin
				ma = 33'(err_q);
				mb = $signed(33'(cfg.time_step));
			end
			OP_INTEG: begin
				ma = $signed(33'(gp_q));
				mb = 33'(err_q);
			end
			OP_KP: begin
				ma = $signed(33'(gi_q));
				mb = 33'(integ_q);
			end
			OP_KD_MUL: begin
				ma = $signed(33'(gd_q));
				mb = 33'(der_q);
			end
			OP_UT_MUL: begin
				ma = 33'(u_q);
				mb = $signed(33'(cfg.torque_gain));
			end
			OP_UT: begin
				ma = $signed(33'(cfg.damping_gain));
				mb = 33'(rate_q);
			end
			OP_ADT_MUL: begin
				ma = 33'(accel_q);
				mb = $signed(33'(cfg.time_step));
			end
			OP_RDT_MUL: begin
				ma = 33'(rate_q);
				mb = $signed(33'(cfg.time_step));
			end
			OP_ANGLE: begin
				ma = 33'(err_q);
				mb = 33'(err_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign mul_full = ma * mb;

	always_comb begin
		sp       = ACC_W'($signed(cfg.setpoint));
		e_wide   = sp - ACC_W'(angle_q);
		e_next   = sat32(e_wide);
		diff     = ACC_W'(e_next) - ACC_W'(last_q);
		mag      = (diff < 0) ? -diff : diff;
		rnd_prod = fx_rnd(ACC_W'(prod_q));
		rnd_acc  = fx_rnd(acc_q);
		qs       = $signed(ACC_W'(div_quo));
		qv       = neg_q ? -qs : qs;
		araw_w   = ACC_W'(araw_q);
		wrap_need = (araw_w > ACC_W'(PI_FIX)) || (araw_w < -ACC_W'(PI_FIX));
		awrap    = (araw_q > 0) ? araw_w - ACC_W'(PI_FIX) - 1 : -ACC_W'(PI_FIX) - araw_w - 1;
		remw     = $signed(ACC_W'(div_rem));
		fixv     = wpos_q ? remw + 1 - ACC_W'(PI_FIX) : ACC_W'(PI_FIX) - 1 - remw;
		sum_next = {1'b0, sum_q} + 49'(rnd_prod);
		trivial  = (runs_q == '0) || sat_q;
		cost_v   = trivial ? COST_MAX : div_quo[47:0];
		better   = cost_v < low_cost_q;
		if (rnd_acc > FORCE_MAX) begin
			u_next = FORCE_MAX[21:0];
		end else if (rnd_acc < -FORCE_MAX) begin
			u_next = 22'(-FORCE_MAX);
		end else begin
			u_next = rnd_acc[21:0];
		end
	end

	// Divider requests: derivative, angle wrap remainder, final mean.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_W'(mag <<< FRAC_BITS);
		div_divisor  = DVS_W'(cfg.time_step);
		if (cmd.op == OP_ERR) begin
			div_start = 1'b1;
		end else if (cmd.op == OP_WRAP && wrap_need) begin
			div_start    = 1'b1;
			div_dividend = DIV_W'(awrap);
			div_divisor  = TWO_PI_FIX;
		end else if (cmd.op == OP_COST && !trivial) begin
			div_start    = 1'b1;
			div_dividend = DIV_W'(sum_q);
			div_divisor  = DVS_W'(runs_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_full[63:0];
		end
		unique case (cmd.op)
			OP_LOAD: begin
				gp_q    <= in_gain_p;
				gi_q    <= in_gain_i;
				gd_q    <= in_gain_d;
				integ_q <= '0;
				last_q  <= '0;
				sum_q   <= '0;
				sat_q   <= 1'b0;
				k_q     <= '0;
				runs_q  <= '0;
				start_q <= 27'($signed(cfg.roll_start));
			end
			OP_SKIP: begin
				k_q     <= k_q + 1'b1;
				start_q <= start_q + $signed(27'(cfg.roll_step));
			end
			OP_RUN_INIT: begin
				angle_q <= 32'(start_q);
				rate_q  <= '0;
				step_q  <= '0;
			end
			OP_RUN_END: begin
				k_q     <= k_q + 1'b1;
				runs_q  <= runs_q + 1'b1;
				start_q <= start_q + $signed(27'(cfg.roll_step));
			end
			OP_ERR: begin
				err_q  <= e_next;
				last_q <= e_next;
				neg_q  <= diff < 0;
				step_q <= step_q + 1'b1;
			end
			OP_INTEG: integ_q <= sat32(ACC_W'(integ_q) + rnd_prod);
			OP_KP: acc_q <= ACC_W'(prod_q);
			OP_KI, OP_KD: acc_q <= acc_q + ACC_W'(prod_q);
			OP_DER: der_q <= (cfg.time_step == '0) ? '0 : sat32(qv);
			OP_U: u_q <= u_next;
			OP_UT: acc_q <= ACC_W'(prod_q);
			OP_DR: acc_q <= acc_q - ACC_W'(prod_q);
			OP_ACCEL: accel_q <= sat32(rnd_acc);
			OP_RATE: rate_q <= sat32(ACC_W'(rate_q) + rnd_prod);
			OP_ANGLE: araw_q <= 35'(ACC_W'(angle_q) + rnd_prod);
			OP_WRAP: begin
				// The product register holds the squared error here.
				wpos_q <= araw_q > 0;
				if (!wrap_need) begin
					angle_q <= araw_q[31:0];
				end
				if (sum_next[48]) begin
					sum_q <= COST_MAX;
					sat_q <= 1'b1;
				end else begin
					sum_q <= sum_next[47:0];
				end
			end
			OP_WRAP_FIX: angle_q <= fixv[31:0];
			OP_FINISH: begin
				cost_q <= cost_v;
				flag_q <= better;
				bp_q   <= better ? gp_q : best_p_q;
				bi_q   <= better ? gi_q : best_i_q;
				bd_q   <= better ? gd_q : best_d_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			low_cost_q <= COST_MAX;
			best_p_q   <= '0;
			best_i_q   <= '0;
			best_d_q   <= '0;
		end else begin
			if (cmd.op == OP_FINISH) begin
				valid_q <= 1'b1;
				if (better) begin
					low_cost_q <= cost_v;
					best_p_q   <= gp_q;
					best_i_q   <= gi_q;
					best_d_q   <= gd_q;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.roll_done  = k_q == cfg.roll_count;
		stat.start_zero = start_q == '0;
		stat.steps_done = step_q == cfg.steps_per_run;
		stat.div_busy   = div_busy;
		stat.wrap_need  = wrap_need;
		stat.out_free   = !valid_q || out_ready;
	end

	assign out_valid    = valid_q;
	assign out_cost     = cost_q;
	assign out_new_best = flag_q;
	assign out_best_p   = bp_q;
	assign out_best_i   = bi_q;
	assign out_best_d   = bd_q;

endmodule

`default_nettype wire

// ===== rtl/core/pcl_ctrl.sv =====
// PID cost search sequencer: walks runs and simulation steps, one op a cycle unless stalled.
// Depends on pcl_pkg for the command and status types.
`default_nettype none

module pcl_ctrl import pcl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	typedef enum logic [21:0] {
		ST_IDLE     = 22'd1 << 0,
		ST_ROLL     = 22'd1 << 1,
		ST_CHECK    = 22'd1 << 2,
		ST_EDT      = 22'd1 << 3,
		ST_INTEG    = 22'd1 << 4,
		ST_KP       = 22'd1 << 5,
		ST_KI       = 22'd1 << 6,
		ST_DER      = 22'd1 << 7,
		ST_KD_MUL   = 22'd1 << 8,
		ST_KD       = 22'd1 << 9,
		ST_U        = 22'd1 << 10,
		ST_UT_MUL   = 22'd1 << 11,
		ST_UT       = 22'd1 << 12,
		ST_DR       = 22'd1 << 13,
		ST_ACCEL    = 22'd1 << 14,
		ST_ADT_MUL  = 22'd1 << 15,
		ST_RATE     = 22'd1 << 16,
		ST_RDT_MUL  = 22'd1 << 17,
		ST_ANGLE    = 22'd1 << 18,
		ST_WRAP     = 22'd1 << 19,
		ST_WRAP_FIX = 22'd1 << 20,
		ST_FINISH   = 22'd1 << 21
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_ROLL;
				end
			end
			ST_ROLL: begin
				if (stat.roll_done) begin
					cmd.op  = OP_COST;
					state_d = ST_FINISH;
				end else if (stat.start_zero) begin
					cmd.op = OP_SKIP;
				end else begin
					cmd.op  = OP_RUN_INIT;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.steps_done) begin
					cmd.op  = OP_RUN_END;
					state_d = ST_ROLL;
				end else begin
					cmd.op  = OP_ERR;
					state_d = ST_EDT;
				end
			end
			ST_EDT: begin
				cmd.op  = OP_EDT;
				state_d = ST_INTEG;
			end
			ST_INTEG: begin
				cmd.op  = OP_INTEG;
				state_d = ST_KP;
			end
			ST_KP: begin
				cmd.op  = OP_KP;
				state_d = ST_KI;
			end
			ST_KI: begin
				cmd.op  = OP_KI;
				state_d = ST_DER;
			end
			ST_DER: begin
				if (!stat.div_busy) begin
					cmd.op  = OP_DER;
					state_d = ST_KD_MUL;
				end
			end
			ST_KD_MUL: begin
				cmd.op  = OP_KD_MUL;
				state_d = ST_KD;
			end
			ST_KD: begin
				cmd.op  = OP_KD;
				state_d = ST_U;
			end
			ST_U: begin
				cmd.op  = OP_U;
				state_d = ST_UT_MUL;
			end
			ST_UT_MUL: begin
				cmd.op  = OP_UT_MUL;
				state_d = ST_UT;
			end
			ST_UT: begin
				cmd.op  = OP_UT;
				state_d = ST_DR;
			end
			ST_DR: begin
				cmd.op  = OP_DR;
				state_d = ST_ACCEL;
			end
			ST_ACCEL: begin
				cmd.op  = OP_ACCEL;
				state_d = ST_ADT_MUL;
			end
			ST_ADT_MUL: begin
				cmd.op  = OP_ADT_MUL;
				state_d = ST_RATE;
			end
			ST_RATE: begin
				cmd.op  = OP_RATE;
				state_d = ST_RDT_MUL;
			end
			ST_RDT_MUL: begin
				cmd.op  = OP_RDT_MUL;
				state_d = ST_ANGLE;
			end
			ST_ANGLE: begin
				cmd.op  = OP_ANGLE;
				state_d = ST_WRAP;
			end
			ST_WRAP: begin
				cmd.op  = OP_WRAP;
				state_d = stat.wrap_need ? ST_WRAP_FIX : ST_CHECK;
			end
			ST_WRAP_FIX: begin
				if (!stat.div_busy) begin
					cmd.op  = OP_WRAP_FIX;
					state_d = ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (!stat.div_busy && stat.out_free) begin
					cmd.op  = OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/pid_closed_loop_cost_search.sv =====
// PID gain cost search: top level with configuration registers and the two stream channels.
// Depends on pcl_pkg, pcl_ctrl, pcl_dp (and through it pcl_div).
//
// Usage:
//  - Each slave-side beat carries one candidate gain triple (kp, ki, kd), unsigned Q9.16.
//    For every configured start angle that is not zero, the block simulates the PID loop
//    against the damped plant for steps_per_run steps and sums the squared errors.
//  - Each master-side beat carries the mean cost (Q32.16, all ones when there was no run
//    or the sum saturated), the new-best flag in tuser, and the best gains so far.
//  - Write registers on the cfg channel (always ready) only while the block is idle; unchecked.
//  - One item at a time. The time of a simulation step is set by the derivative
//    division in the radix-4 divider plus the chain of dependent multiplies through
//    the single shared 33x33 multiplier; a step whose angle leaves +-pi also waits
//    for the divider to give the wrap remainder.
//  - The result sits in an output register: a new item is taken while it waits, and the
//    finished result of that item is held back until the receiver has taken the old one.
//  - Reset sets the registers to their defaults, clears the best cost to all ones and the
//    best gains to zero, and empties the output register.
`default_nettype none

module pid_closed_loop_cost_search import pcl_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [79:0]  s_tdata,   // gain_p[24:0], gain_i[49:25], gain_d[74:50]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // cost[47:0], best_p[72:48], best_i[97:73], best_d[122:98]
	output logic [0:0]        m_tuser,   // is_new_best[0]
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [30:0]  cfg_data
);

	cfg_t        cfg_q;
	cmd_t        cmd;
	stat_t       stat;
	logic [47:0] cost;
	logic        new_best;
	logic [24:0] best_p, best_i, best_d;

	// Configuration registers; the write channel never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SETPOINT:   cfg_q.setpoint      <= cfg_data[18:0];
				CFG_TIME_STEP:  cfg_q.time_step     <= cfg_data[16:0];
				CFG_STEPS:      cfg_q.steps_per_run <= cfg_data[11:0];
				CFG_ROLL_START: cfg_q.roll_start    <= cfg_data[18:0];
				CFG_ROLL_STEP:  cfg_q.roll_step     <= cfg_data[17:0];
				CFG_ROLL_COUNT: cfg_q.roll_count    <= cfg_data[6:0];
				CFG_TORQUE:     cfg_q.torque_gain   <= cfg_data[30:0];
				CFG_DAMPING:    cfg_q.damping_gain  <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	pcl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pcl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.stat         (stat),
		.in_gain_p    (s_tdata[24:0]),
		.in_gain_i    (s_tdata[49:25]),
		.in_gain_d    (s_tdata[74:50]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_cost     (cost),
		.out_new_best (new_best),
		.out_best_p   (best_p),
		.out_best_i   (best_i),
		.out_best_d   (best_d)
	);

	assign m_tdata = {5'd0, best_d, best_i, best_p, cost};
	assign m_tuser = new_best;

endmodule

`default_nettype wire

// ===== tb/tb_pid_closed_loop_cost_search.sv =====
// Self-checking testbench of the PID gain cost search block: directed and random candidates
// under many register settings, predicted cycle-free and compared beat by beat.
// Depends on pcl_pkg and pid_closed_loop_cost_search.
`timescale 1ns / 1ps

module tb_pid_closed_loop_cost_search;
	import pcl_pkg::*;

	// The slowest item sent here is one 4095-step run; everything else is far shorter,
	// so this limit leaves a wide margin.
	localparam longint CYCLE_LIMIT = 8_000_000;
	localparam logic [24:0] GAIN_MAX = {25{1'b1}};

	// Scoreboard: holds the register copy, the best-so-far state and the queue of
	// expected cost beats, one per accepted candidate.
	class cost_scoreboard;
		typedef struct {
			logic [47:0] cost;
			logic        new_best;
			logic [24:0] bp, bi, bd;
		} cost_beat_t;

		cfg_t        regs;
		logic [47:0] low_cost;
		logic [24:0] best_g [3];
		cost_beat_t  expected_costs [$];
		int          errors;

		function new();
			regs = CFG_RESET;
			low_cost = COST_MAX;
			foreach (best_g[n]) best_g[n] = '0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function void write_reg(cfg_idx_t idx, logic [30:0] v);
			case (idx)
				CFG_SETPOINT:   regs.setpoint      = v[18:0];
				CFG_TIME_STEP:  regs.time_step     = v[16:0];
				CFG_STEPS:      regs.steps_per_run = v[11:0];
				CFG_ROLL_START: regs.roll_start    = v[18:0];
				CFG_ROLL_STEP:  regs.roll_step     = v[17:0];
				CFG_ROLL_COUNT: regs.roll_count    = v[6:0];
				CFG_TORQUE:     regs.torque_gain   = v;
				CFG_DAMPING:    regs.damping_gain  = v;
				default: ;
			endcase
		endfunction

		static function longint clip32(longint v);
			if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
			if (v < -64'sh8000_0000) return -64'sh8000_0000;
			return v;
		endfunction

		// Round half up, then floor: matches the datapath's rounding shift after a multiply or a sum of products.
		static function longint rnd(longint v);
			return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		endfunction

		static function longint wrap_pi(longint a);
			longint pi_q, two_pi, n;
			pi_q = longint'(PI_FIX);
			two_pi = 2 * pi_q;
			if (a > pi_q) begin
				n = (a - pi_q + two_pi - 1) / two_pi;
				a -= n * two_pi;
			end else if (a < -pi_q) begin
				n = (-pi_q - a + two_pi - 1) / two_pi;
				a += n * two_pi;
			end
			return a;
		endfunction

		// Runs the whole closed-loop sweep for one candidate and queues the result.
		function void note_candidate(logic [24:0] kp_in, logic [24:0] ki_in, logic [24:0] kd_in);
			longint kp, ki, kd, sp, rs, dt, tg, dg, start, err, der, u, acc;
			longint integ, last_err, angle, rate;
			longint unsigned esum, sq, runs, cost;
			bit sat;
			cost_beat_t b;
			kp = kp_in; ki = ki_in; kd = kd_in;
			sp = longint'($signed(regs.setpoint));
			rs = longint'($signed(regs.roll_start));
			dt = regs.time_step;
			tg = regs.torque_gain;
			dg = regs.damping_gain;
			integ = 0; last_err = 0; esum = 0; runs = 0; sat = 0;
			for (int k = 0; k < regs.roll_count; k++) begin
				start = rs + longint'(k) * longint'(regs.roll_step);
				if (start == 0) continue;
				angle = clip32(start);
				rate = 0;
				for (int s = 0; s < regs.steps_per_run; s++) begin
					err = clip32(sp - angle);
					integ = clip32(integ + rnd(err * dt));
					der = 0;
					if (dt != 0) der = clip32(((err - last_err) * (longint'(1) <<< FRAC_BITS)) / dt);
					last_err = err;
					u = rnd(kp * err + ki * integ + kd * der);
					if (u > (longint'(20) <<< FRAC_BITS)) u = longint'(20) <<< FRAC_BITS;
					if (u < -(longint'(20) <<< FRAC_BITS)) u = -(longint'(20) <<< FRAC_BITS);
					acc = clip32(rnd(u * tg - dg * rate));
					rate = clip32(rate + rnd(acc * dt));
					angle = wrap_pi(angle + rnd(rate * dt));
					sq = (longint'(unsigned'(err * err)) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
					esum += sq;
					if (esum > 64'hFFFF_FFFF_FFFF) begin
						esum = 64'hFFFF_FFFF_FFFF;
						sat = 1;
					end
				end
				runs++;
			end
			cost = (runs == 0 || sat) ? 64'hFFFF_FFFF_FFFF : esum / runs;
			b.new_best = (cost[47:0] < low_cost);
			if (b.new_best) begin
				low_cost = cost[47:0];
				best_g[0] = kp_in; best_g[1] = ki_in; best_g[2] = kd_in;
			end
			b.cost = cost[47:0];
			b.bp = best_g[0]; b.bi = best_g[1]; b.bd = best_g[2];
			expected_costs.push_back(b);
		endfunction

		task check_result(logic [47:0] cost, logic flag, logic [24:0] bp,
				logic [24:0] bi, logic [24:0] bd);
			cost_beat_t b;
			if (expected_costs.size() == 0) begin
				report($sformatf("unexpected result beat, cost %0h", cost));
				return;
			end
			b = expected_costs.pop_front();
			if (cost !== b.cost) report($sformatf("cost %0h, expected %0h", cost, b.cost));
			if (flag !== b.new_best) report($sformatf("new-best %b, expected %b", flag, b.new_best));
			if (bp !== b.bp) report($sformatf("best_p %0h, expected %0h", bp, b.bp));
			if (bi !== b.bi) report($sformatf("best_i %0h, expected %0h", bi, b.bi));
			if (bd !== b.bd) report($sformatf("best_d %0h, expected %0h", bd, b.bd));
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [79:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [30:0]  cfg_data = '0;

	cost_scoreboard sb = new();
	longint cycles = 0;
	// When set, neither side idles: back-to-back beats for a whole phase.
	bit     no_idle = 1'b0;

	pid_closed_loop_cost_search u_top (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_pid_closed_loop_cost_search: FAIL");
			$finish;
		end
	end

	// Monitors sample at the rising edge, where the handshake completes. A candidate is
	// predicted the moment its beat is taken, so expectations stay in input order.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_candidate(s_tdata[24:0], s_tdata[49:25], s_tdata[74:50]);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[47:0], m_tuser[0], m_tdata[72:48], m_tdata[97:73],
				m_tdata[122:98]);
	end

	// Receiver: a fresh stall before every result beat; ready then stays high until a
	// beat is taken, so each stall falls right after the beat before it.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Sends one candidate beat. Valid is kept high across a zero gap so it is never
	// dropped and raised again in the same time step.
	task automatic send_gains(logic [24:0] p, logic [24:0] i, logic [24:0] d);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tdata <= {5'b0, d, i, p};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random_gains();
		logic [24:0] g [3];
		foreach (g[n]) begin
			case ($urandom_range(0, 3))
				0: g[n] = 25'($urandom);
				1: g[n] = 25'($urandom_range(0, 32'h3_FFFF));
				2: g[n] = 25'($urandom_range(0, 32'hFFFF));
				default: g[n] = ($urandom_range(0, 7) == 0) ? GAIN_MAX : 25'($urandom_range(0, 16));
			endcase
		end
		send_gains(g[0], g[1], g[2]);
	endtask

	// Waits until every expected cost beat has arrived; each candidate gives exactly one,
	// so the block is idle then. Spare cycles follow anyway.
	task automatic drain();
		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.expected_costs.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [30:0] v);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
	endtask

	task automatic write_all(int sp, int dt, int steps, int rs, int rstep, int cnt,
			logic [30:0] tg, logic [30:0] dg);
		write_reg(CFG_SETPOINT, 31'(sp));
		write_reg(CFG_TIME_STEP, 31'(dt));
		write_reg(CFG_STEPS, 31'(steps));
		write_reg(CFG_ROLL_START, 31'(rs));
		write_reg(CFG_ROLL_STEP, 31'(rstep));
		write_reg(CFG_ROLL_COUNT, 31'(cnt));
		write_reg(CFG_TORQUE, tg);
		write_reg(CFG_DAMPING, dg);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Random settings kept cheap in steps and runs; the other registers take wide random values.
	task automatic write_random_cfg();
		logic [30:0] tg, dg;
		tg = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom_range(0, 5000));
		dg = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom_range(0, 5000));
		write_all($urandom_range(0, 2 * 205887) - 205887,
			($urandom_range(0, 3) == 0) ? $urandom_range(1, 65536) : $urandom_range(1, 8000),
			($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
			$urandom_range(0, 2 * 205887) - 205887,
			$urandom_range(1, 205887), $urandom_range(1, 4), tg, dg);
	endtask

	initial begin
		int phase_items;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Reset settings: zero and full-scale gains, then the same candidate twice so the
		// second one ties the best cost and must not replace it.
		send_gains('0, '0, '0);
		send_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
		send_gains(25'h1_0000, 25'h0_2000, 25'h0_0800);
		send_gains(25'h1_0000, 25'h0_2000, 25'h0_0800);
		drain();

		// One of the start angles lands exactly on zero and is skipped.
		write_all(0, 6554, 3, -40000, 20000, 5, 1260, 840);
		send_gains(25'h2_0000, 25'h0_1000, 25'h0_4000);
		send_gains(25'h0_8000, '0, GAIN_MAX);
		drain();

		// The only start angle is zero: no runs, all-ones cost, never a new best.
		write_all(1000, 6554, 3, 0, 1, 1, 1260, 840);
		send_gains(25'h1, 25'h1, 25'h1);
		drain();

		// Zero steps per run, then a zero time step with the derivative forced to zero.
		// Registers change only once the block has gone idle.
		write_all(-1000, 0, 0, 30000, 5, 2, 1260, 840);
		send_gains(25'h3_0000, 25'h3, 25'h3_0000);
		drain();
		write_all(-1000, 0, 2, 30000, 5, 2, 1260, 840);
		send_gains(25'h3_0000, 25'h1_0000, 25'h3_0000);
		drain();

		// Register extremes: widest angles, a sweep of 64 start angles, largest plant gains.
		write_all(205887, 65536, 1, -205887, 205887, 64, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_gains(GAIN_MAX, '0, GAIN_MAX);
		send_gains('0, GAIN_MAX, '0);
		drain();
		write_all(-205887, 1, 2, 205887, 1, 3, 0, 0);
		send_gains(GAIN_MAX, GAIN_MAX, '0);
		drain();

		// The one long run: the largest step count on a single start angle.
		write_all(0, 6554, 4095, 51472, 1, 1, 1260, 840);
		send_gains(25'h1_0000, 25'h0_1000, 25'h0_1000);
		drain();

		// Random phases, each under new settings; one in four runs with no idling at all.
		for (int ph = 0; ph < 10; ph++) begin
			no_idle = ($urandom_range(0, 3) == 0);
			write_random_cfg();
			phase_items = 14;
			repeat (phase_items) send_random_gains();
			drain();
		end
		no_idle = 1'b0;

		repeat (50) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_pid_closed_loop_cost_search: PASS");
		end else begin
			$display("tb_pid_closed_loop_cost_search: FAIL");
		end
		$finish;
	end

endmodule
